[sv/lavm_pkg.sv]
// Shared types and constants for the look-at view matrix block.
package lavm_pkg;

    // Width of every input and result field.
    localparam int unsigned FieldW = 32;
    // Width of a view direction after the target difference.
    localparam int unsigned DirW = 33;
    // Width of the cross and dot accumulators and of the normalizer input.
    localparam int unsigned AccW = 66;

    typedef logic signed [FieldW-1:0] fld_t;

    // One input transaction.
    typedef struct packed {
        logic func;
        fld_t pos_x;
        fld_t pos_y;
        fld_t pos_z;
        fld_t vec_x;
        fld_t vec_y;
        fld_t vec_z;
        fld_t up_x;
        fld_t up_y;
        fld_t up_z;
    } lavm_in_t;

    // One result transaction.
    typedef struct packed {
        fld_t right_x;
        fld_t right_y;
        fld_t right_z;
        fld_t cam_up_x;
        fld_t cam_up_y;
        fld_t cam_up_z;
        fld_t fwd_x;
        fld_t fwd_y;
        fld_t fwd_z;
        fld_t trans_x;
        fld_t trans_y;
        fld_t trans_z;
    } lavm_out_t;

    // A classified job as it waits in the queue.
    typedef struct packed {
        fld_t pos_x;
        fld_t pos_y;
        fld_t pos_z;
        logic signed [DirW-1:0] dir_x;
        logic signed [DirW-1:0] dir_y;
        logic signed [DirW-1:0] dir_z;
        fld_t up_x;
        fld_t up_y;
        fld_t up_z;
    } lavm_job_t;

    // Head of the job queue as seen by the back end.
    typedef struct packed {
        logic      valid;
        lavm_job_t job;
    } lavm_qhead_t;

endpackage

[sv/lavm_front.sv]
// Front end: accepts transactions, forms the view direction and queues jobs.
module lavm_front
    import lavm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  lavm_in_t    item,
    output logic        busy,
    output lavm_qhead_t head,
    input  logic        pop
);

    localparam int unsigned Depth = 2;

    lavm_job_t  q_reg [Depth];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       accept;
    lavm_job_t  job;

    assign busy   = (cnt_reg == 2'(Depth));
    assign accept = start && !busy;

    // Direction is taken as given or formed as target minus position at full width.
    always_comb
    begin
        job.pos_x = item.pos_x;
        job.pos_y = item.pos_y;
        job.pos_z = item.pos_z;
        job.up_x  = item.up_x;
        job.up_y  = item.up_y;
        job.up_z  = item.up_z;
        if (item.func)
        begin
            job.dir_x = DirW'(item.vec_x) - DirW'(item.pos_x);
            job.dir_y = DirW'(item.vec_y) - DirW'(item.pos_y);
            job.dir_z = DirW'(item.vec_z) - DirW'(item.pos_z);
        end
        else
        begin
            job.dir_x = DirW'(item.vec_x);
            job.dir_y = DirW'(item.vec_y);
            job.dir_z = DirW'(item.vec_z);
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= job;
        end
    end

    // Queue pointers and fill count.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!accept && pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.job   = q_reg[rd_ptr_reg];

endmodule

[sv/lavm_norm.sv]
// Iterative vector normalizer: power-of-two scaling, sum of squares, square root, division.
module lavm_norm
    import lavm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   go,
    input  logic signed [AccW-1:0] vin [3],
    output logic                   done,
    output fld_t                   vout [3]
);

    localparam int unsigned NumW = 32 + FRAC_BITS;
    localparam int unsigned LowW = FRAC_BITS + 2;
    localparam int unsigned CntW = $clog2(FRAC_BITS + 3);
    localparam logic [AccW-1:0] TopLim = AccW'(1) << 31;
    localparam logic [AccW-1:0] BotLim = AccW'(1) << 30;
    localparam logic [63:0] RootBit0 = 64'(1) << 62;

    typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_ROOT, N_DIV} nstate_t;

    nstate_t           state_reg;
    logic              neg_reg [3];
    logic [AccW-1:0]   m_reg [3];
    logic [AccW-1:0]   mx_reg;
    logic [61:0]       sq_reg;
    logic [63:0]       s_reg;
    logic [63:0]       root_reg;
    logic [63:0]       bit_reg;
    logic [1:0]        k_reg;
    logic              ph_reg;
    logic [CntW-1:0]   cnt_reg;
    logic [31:0]       rem_reg;
    logic [LowW-1:0]   low_reg;
    logic [LowW-1:0]   q_reg;
    fld_t              vout_reg [3];
    logic              done_reg;

    logic [AccW-1:0]   mag_in [3];
    logic [AccW-1:0]   mx_in;
    logic [64:0]       trial;
    logic              root_ge;
    logic [NumW-1:0]   num;
    logic [32:0]       dt;
    logic              qbit;
    logic [LowW-1:0]   q_fin;
    logic [30:0]       mk;

    // Magnitudes and largest magnitude of the incoming vector.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_in[i] = vin[i][AccW-1] ? AccW'(-vin[i]) : AccW'(vin[i]);
        end
        mx_in = mag_in[0];
        if (mag_in[1] > mx_in)
        begin
            mx_in = mag_in[1];
        end
        if (mag_in[2] > mx_in)
        begin
            mx_in = mag_in[2];
        end
    end

    // One square-root step per cycle.
    assign trial   = {1'b0, root_reg} + {1'b0, bit_reg};
    assign root_ge = {1'b0, s_reg} >= trial;

    // One quotient bit per cycle; the rounding offset is folded into the numerator.
    assign mk    = m_reg[k_reg][30:0];
    assign num   = (NumW'(mk) << FRAC_BITS) + NumW'(root_reg[31:1]);
    assign dt    = {rem_reg, low_reg[LowW-1]};
    assign qbit  = dt >= {1'b0, root_reg[31:0]};
    assign q_fin = {q_reg[LowW-2:0], qbit};

    // Sequencer and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
            mx_reg    <= '0;
            sq_reg    <= '0;
            s_reg     <= '0;
            root_reg  <= '0;
            bit_reg   <= '0;
            k_reg     <= 2'd0;
            ph_reg    <= 1'b0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            low_reg   <= '0;
            q_reg     <= '0;
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i]  <= 1'b0;
                m_reg[i]    <= '0;
                vout_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                N_IDLE:
                begin
                    if (go)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            neg_reg[i] <= vin[i][AccW-1];
                            m_reg[i]   <= mag_in[i];
                        end
                        mx_reg    <= mx_in;
                        state_reg <= N_SHIFT;
                    end
                end
                N_SHIFT:
                begin
                    // Bring the largest magnitude into [2^30, 2^31) one bit a cycle.
                    if (mx_reg == '0)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            vout_reg[i] <= '0;
                        end
                        done_reg  <= 1'b1;
                        state_reg <= N_IDLE;
                    end
                    else if (mx_reg >= TopLim)
                    begin
                        mx_reg <= mx_reg >> 1;
                        for (int i = 0; i < 3; i++)
                        begin
                            m_reg[i] <= m_reg[i] >> 1;
                        end
                    end
                    else if (mx_reg < BotLim)
                    begin
                        mx_reg <= mx_reg << 1;
                        for (int i = 0; i < 3; i++)
                        begin
                            m_reg[i] <= m_reg[i] << 1;
                        end
                    end
                    else
                    begin
                        s_reg     <= '0;
                        k_reg     <= 2'd0;
                        ph_reg    <= 1'b0;
                        state_reg <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    // Square, then accumulate, one component at a time.
                    if (!ph_reg)
                    begin
                        sq_reg <= 62'(mk) * 62'(mk);
                        ph_reg <= 1'b1;
                    end
                    else
                    begin
                        s_reg  <= s_reg + 64'(sq_reg);
                        ph_reg <= 1'b0;
                        if (k_reg == 2'd2)
                        begin
                            root_reg  <= '0;
                            bit_reg   <= RootBit0;
                            state_reg <= N_ROOT;
                        end
                        else
                        begin
                            k_reg <= k_reg + 2'd1;
                        end
                    end
                end
                N_ROOT:
                begin
                    if (root_ge)
                    begin
                        s_reg    <= s_reg - trial[63:0];
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        k_reg     <= 2'd0;
                        ph_reg    <= 1'b0;
                        state_reg <= N_DIV;
                    end
                end
                N_DIV:
                begin
                    if (!ph_reg)
                    begin
                        rem_reg <= 32'(num[NumW-1:LowW]);
                        low_reg <= num[LowW-1:0];
                        q_reg   <= '0;
                        cnt_reg <= '0;
                        ph_reg  <= 1'b1;
                    end
                    else
                    begin
                        if (qbit)
                        begin
                            rem_reg <= 32'(dt - {1'b0, root_reg[31:0]});
                        end
                        else
                        begin
                            rem_reg <= dt[31:0];
                        end
                        q_reg   <= q_fin;
                        low_reg <= low_reg << 1;
                        cnt_reg <= cnt_reg + CntW'(1);
                        if (cnt_reg == CntW'(LowW - 1))
                        begin
                            vout_reg[k_reg] <= neg_reg[k_reg] ? -FieldW'(q_fin)
                                                              : FieldW'(q_fin);
                            ph_reg <= 1'b0;
                            if (k_reg == 2'd2)
                            begin
                                done_reg  <= 1'b1;
                                state_reg <= N_IDLE;
                            end
                            else
                            begin
                                k_reg <= k_reg + 2'd1;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign vout = vout_reg;

endmodule

[sv/lavm_back.sv]
// Back end: builds the camera basis and translation for one queued job at a time.
module lavm_back
    import lavm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  lavm_qhead_t head,
    output logic        pop,
    output logic        done,
    output lavm_out_t   result
);

    localparam logic [AccW-1:0] Half   = AccW'(1) << (FRAC_BITS - 1);
    localparam logic [AccW-1:0] OneMag = AccW'(1) << FRAC_BITS;
    localparam logic [AccW-1:0] NegLim = AccW'(1) << 31;
    localparam logic [AccW-1:0] PosLim = (AccW'(1) << 31) - AccW'(1);

    typedef enum logic [2:0] {B_IDLE, B_NW, B_XC, B_NUGO, B_NU, B_XV, B_DOT, B_FIN}
        bstate_t;
    typedef enum logic [1:0] {PH_MUL, PH_ACC, PH_FIN} phase_t;

    bstate_t                state_reg;
    phase_t                 ph_reg;
    logic [1:0]             comp_reg;
    logic [1:0]             term_reg;
    fld_t                   pos_reg [3];
    fld_t                   up_reg [3];
    fld_t                   w_reg [3];
    fld_t                   u_reg [3];
    fld_t                   v_reg [3];
    fld_t                   t_reg [3];
    logic signed [AccW-1:0] nin_reg [3];
    logic                   go_reg;
    logic signed [63:0]     prod_reg;
    logic signed [AccW-1:0] acc_reg;
    lavm_out_t              res_reg;
    logic                   done_reg;

    logic                   ndone;
    fld_t                   nout [3];
    logic [1:0]             ia;
    logic [1:0]             ib;
    fld_t                   a_op;
    fld_t                   b_op;
    logic signed [63:0]     prod_c;
    logic                   is_cross;
    logic                   last_term;
    logic signed [AccW-1:0] acc_base;
    logic signed [AccW-1:0] sum;
    logic [AccW-1:0]        amag;
    logic [AccW-1:0]        rmag;
    fld_t                   v_rnd;
    fld_t                   t_rnd;

    function automatic logic [1:0] idx_nxt(input logic [1:0] c);
        logic [1:0] r;
        case (c)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] idx_prv(input logic [1:0] c);
        logic [1:0] r;
        case (c)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    lavm_norm #(
        .FRAC_BITS(FRAC_BITS)
    ) u_norm (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (go_reg),
        .vin  (nin_reg),
        .done (ndone),
        .vout (nout)
    );

    assign pop = (state_reg == B_IDLE) && head.valid;

    // Operand selection for the shared multiplier.
    assign is_cross = (state_reg == B_XC) || (state_reg == B_XV);

    always_comb
    begin
        if (is_cross)
        begin
            ia = (term_reg == 2'd0) ? idx_nxt(comp_reg) : idx_prv(comp_reg);
            ib = (term_reg == 2'd0) ? idx_prv(comp_reg) : idx_nxt(comp_reg);
        end
        else
        begin
            ia = term_reg;
            ib = term_reg;
        end
        a_op = w_reg[ia];
        b_op = pos_reg[ib];
        case (state_reg)
            B_XC:
            begin
                b_op = up_reg[ib];
            end
            B_XV:
            begin
                b_op = u_reg[ib];
            end
            B_DOT:
            begin
                case (comp_reg)
                    2'd0:    a_op = u_reg[ia];
                    2'd1:    a_op = v_reg[ia];
                    default: a_op = w_reg[ia];
                endcase
            end
            default:
            begin
                b_op = pos_reg[ib];
            end
        endcase
    end

    assign prod_c    = a_op * b_op;
    assign last_term = is_cross ? (term_reg == 2'd1) : (term_reg == 2'd2);
    assign acc_base  = (term_reg == 2'd0) ? '0 : acc_reg;
    assign sum       = (is_cross && term_reg == 2'd1) ? acc_base - AccW'(prod_reg)
                                                      : acc_base + AccW'(prod_reg);

    // Round half away from zero to the output fraction, then clamp or saturate.
    always_comb
    begin
        amag = acc_reg[AccW-1] ? AccW'(-acc_reg) : AccW'(acc_reg);
        rmag = (amag + Half) >> FRAC_BITS;
        if (rmag > OneMag)
        begin
            v_rnd = acc_reg[AccW-1] ? -FieldW'(OneMag) : FieldW'(OneMag);
        end
        else
        begin
            v_rnd = acc_reg[AccW-1] ? -FieldW'(rmag) : FieldW'(rmag);
        end
        if (!acc_reg[AccW-1])
        begin
            t_rnd = (rmag > NegLim) ? FieldW'(NegLim) : -FieldW'(rmag);
        end
        else
        begin
            t_rnd = (rmag > PosLim) ? FieldW'(PosLim) : FieldW'(rmag);
        end
    end

    // Job sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ph_reg    <= PH_MUL;
            comp_reg  <= 2'd0;
            term_reg  <= 2'd0;
            go_reg    <= 1'b0;
            done_reg  <= 1'b0;
            prod_reg  <= '0;
            acc_reg   <= '0;
            res_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                up_reg[i]  <= '0;
                w_reg[i]   <= '0;
                u_reg[i]   <= '0;
                v_reg[i]   <= '0;
                t_reg[i]   <= '0;
                nin_reg[i] <= '0;
            end
        end
        else
        begin
            go_reg   <= 1'b0;
            done_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (head.valid)
                    begin
                        pos_reg[0] <= head.job.pos_x;
                        pos_reg[1] <= head.job.pos_y;
                        pos_reg[2] <= head.job.pos_z;
                        up_reg[0]  <= head.job.up_x;
                        up_reg[1]  <= head.job.up_y;
                        up_reg[2]  <= head.job.up_z;
                        nin_reg[0] <= AccW'(head.job.dir_x);
                        nin_reg[1] <= AccW'(head.job.dir_y);
                        nin_reg[2] <= AccW'(head.job.dir_z);
                        go_reg     <= 1'b1;
                        state_reg  <= B_NW;
                    end
                end
                B_NW:
                begin
                    if (ndone)
                    begin
                        w_reg     <= nout;
                        comp_reg  <= 2'd0;
                        term_reg  <= 2'd0;
                        ph_reg    <= PH_MUL;
                        state_reg <= B_XC;
                    end
                end
                B_XC, B_XV, B_DOT:
                begin
                    case (ph_reg)
                        PH_MUL:
                        begin
                            prod_reg <= prod_c;
                            ph_reg   <= PH_ACC;
                        end
                        PH_ACC:
                        begin
                            acc_reg <= sum;
                            if (last_term)
                            begin
                                ph_reg <= PH_FIN;
                            end
                            else
                            begin
                                ph_reg   <= PH_MUL;
                                term_reg <= term_reg + 2'd1;
                            end
                        end
                        default:
                        begin
                            // Store the finished component.
                            if (state_reg == B_XC)
                            begin
                                nin_reg[comp_reg] <= acc_reg;
                            end
                            else if (state_reg == B_XV)
                            begin
                                v_reg[comp_reg] <= v_rnd;
                            end
                            else
                            begin
                                t_reg[comp_reg] <= t_rnd;
                            end
                            term_reg <= 2'd0;
                            ph_reg   <= PH_MUL;
                            if (comp_reg == 2'd2)
                            begin
                                comp_reg <= 2'd0;
                                if (state_reg == B_XC)
                                begin
                                    state_reg <= B_NUGO;
                                end
                                else if (state_reg == B_XV)
                                begin
                                    state_reg <= B_DOT;
                                end
                                else
                                begin
                                    state_reg <= B_FIN;
                                end
                            end
                            else
                            begin
                                comp_reg <= comp_reg + 2'd1;
                            end
                        end
                    endcase
                end
                B_NUGO:
                begin
                    go_reg    <= 1'b1;
                    state_reg <= B_NU;
                end
                B_NU:
                begin
                    if (ndone)
                    begin
                        u_reg     <= nout;
                        comp_reg  <= 2'd0;
                        term_reg  <= 2'd0;
                        ph_reg    <= PH_MUL;
                        state_reg <= B_XV;
                    end
                end
                B_FIN:
                begin
                    res_reg.right_x  <= u_reg[0];
                    res_reg.right_y  <= u_reg[1];
                    res_reg.right_z  <= u_reg[2];
                    res_reg.cam_up_x <= v_reg[0];
                    res_reg.cam_up_y <= v_reg[1];
                    res_reg.cam_up_z <= v_reg[2];
                    res_reg.fwd_x    <= w_reg[0];
                    res_reg.fwd_y    <= w_reg[1];
                    res_reg.fwd_z    <= w_reg[2];
                    res_reg.trans_x  <= t_reg[0];
                    res_reg.trans_y  <= t_reg[1];
                    res_reg.trans_z  <= t_reg[2];
                    done_reg         <= 1'b1;
                    state_reg        <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

[sv/look_at_view_matrix_core.sv]
// Top level of the look-at view matrix block.
//
// A transaction is taken at a rising edge where start is high and busy is low.
// The item carries the eye position, a view direction or target point (func)
// and a reference up vector, all signed fixed point with FRAC_BITS fraction
// bits. Each result is shown on result for exactly one cycle with done high;
// the receiver cannot stall, so a result is never held back.
// The front end forms the direction and places the job in a two-entry queue;
// busy is high only while that queue is full, so up to two further
// transactions are taken while a job is being worked on.
// The back end runs one job at a time through one shared normalizer and one
// shared 32x32 multiplier. Each normalization does one-bit scaling to a
// power-of-two range, squaring of the three components, 32 square-root
// steps and 3 divisions; the cross products and dot products take 21
// multiply steps, each a multiply and then an accumulate, and a store for
// each of the 9 components. A normalization ends early when its input is
// zero, as when the direction or the right axis is zero.
// Reset empties the queue and returns both sequencers to idle; no result is
// pending afterwards.
module look_at_view_matrix_core
    import lavm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  lavm_in_t  item,
    output logic      busy,
    output logic      done,
    output lavm_out_t result
);

    lavm_qhead_t head;
    logic        pop;

    lavm_front u_front (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .item (item),
        .busy (busy),
        .head (head),
        .pop  (pop)
    );

    lavm_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .done  (done),
        .result(result)
    );

    // The back end only takes a job that is present in the queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head.valid)
        else $error("job taken from an empty queue");

    // An accepted transaction leaves the queue non-empty.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> head.valid)
        else $error("accepted transaction lost from the queue");

    // Done is never high in back-to-back cycles.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for two cycles");

    // A full queue always presents a job to the back end.
    assert property (@(posedge clk) disable iff (!rst_n) busy |-> head.valid)
        else $error("queue full but head empty");

endmodule
